>>> rtl/core/compass_heading_from_xy_defines.svh
// Assertion macros for the compass heading block.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef COMPASS_HEADING_FROM_XY_DEFINES_SVH
`define COMPASS_HEADING_FROM_XY_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHP_ASSERT_IMP(lbl, ante, cons)
`define CHP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/chp_pkg.sv
// Package for the compass heading block: widths, the vector type carried
// between cells, heading offsets and the arctangent table. No dependencies.
package chp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TAB_LEN       = 24;
  localparam int N_CELLS       = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int IDX_W         = 5;
  localparam int ANG_FRAC      = 24;
  localparam int VW            = 44;  // vector words: 19 integer bits, 24 fraction, sign
  localparam int ZW            = 32;  // angle accumulator, degrees with 24 fraction bits
  localparam int BW            = 9;   // base angle offset by 180, 0..360
  localparam int HW            = 36;  // base plus angle

  localparam logic [BW-1:0] OFF_ZERO     = 9'd180;
  localparam logic [BW-1:0] OFF_POS_HALF = 9'd360;
  localparam logic [BW-1:0] OFF_NEG_HALF = 9'd0;
  localparam logic [BW-1:0] OFF_UP       = 9'd270;
  localparam logic [BW-1:0] OFF_DOWN     = 9'd90;
  localparam logic [8:0]    HEAD_MAX     = 9'd360;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic        [BW-1:0] base;
  } vec_t;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_deg(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = 32'sd754974720;
      5'd1:    a = 32'sd445687602;
      5'd2:    a = 32'sd235489088;
      5'd3:    a = 32'sd119537938;
      5'd4:    a = 32'sd60000934;
      5'd5:    a = 32'sd30029717;
      5'd6:    a = 32'sd15018523;
      5'd7:    a = 32'sd7509720;
      5'd8:    a = 32'sd3754917;
      5'd9:    a = 32'sd1877466;
      5'd10:   a = 32'sd938734;
      5'd11:   a = 32'sd469367;
      5'd12:   a = 32'sd234684;
      5'd13:   a = 32'sd117342;
      5'd14:   a = 32'sd58671;
      5'd15:   a = 32'sd29335;
      5'd16:   a = 32'sd14668;
      5'd17:   a = 32'sd7334;
      5'd18:   a = 32'sd3667;
      5'd19:   a = 32'sd1833;
      5'd20:   a = 32'sd917;
      5'd21:   a = 32'sd458;
      5'd22:   a = 32'sd229;
      5'd23:   a = 32'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/compass_heading_from_xy.sv
// Compass heading top level: entry cell, chain of CORDIC cells, exit cell.
// Depends on chp_pkg, chp_pre_cell, chp_cordic_cell, chp_out_cell and the defines header.
//
//   channel | handshake           | payload
//   in      | in_valid, in_ready  | axis_x[15:0], axis_y[15:0] signed
//   out     | out_valid, out_ready| heading_deg[8:0] unsigned
//
// One item enters per cycle while in_ready is high; each item passes through the registers of
// one entry cell, one cell per rotation and one exit cell, in that order.
// Reset clears only the valid bit of every cell.
// Every cell holds its item while it is full and its neighbour downstream cannot
// take it; empty cells keep accepting, so bubbles close up behind a stalled output.
`include "compass_heading_from_xy_defines.svh"

module compass_heading_from_xy (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         heading_deg
);

  chp_pkg::vec_t d [chp_pkg::N_CELLS+1];
  logic          v [chp_pkg::N_CELLS+1];
  logic          r [chp_pkg::N_CELLS+1];

  chp_pre_cell u_pre (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .axis_x   (axis_x),
    .axis_y   (axis_y),
    .dn_valid (v[0]),
    .dn_ready (r[0]),
    .dn_data  (d[0])
  );

  for (genvar i = 0; i < chp_pkg::N_CELLS; i++) begin : g_cell
    chp_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (chp_pkg::IDX_W'(i)),
      .up_valid (v[i]),
      .up_ready (r[i]),
      .up_data  (d[i]),
      .dn_valid (v[i+1]),
      .dn_ready (r[i+1]),
      .dn_data  (d[i+1])
    );
  end

  chp_out_cell u_out (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (v[chp_pkg::N_CELLS]),
    .up_ready    (r[chp_pkg::N_CELLS]),
    .up_data     (d[chp_pkg::N_CELLS]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .heading_deg (heading_deg)
  );

  // a zero sample enters as the null vector with the 180 degree base
  `CHP_ASSERT_NXT(a_zero_entry, in_valid && in_ready && axis_x == 16'sd0 && axis_y == 16'sd0, v[0] && d[0].x == '0 && d[0].y == '0 && d[0].base == chp_pkg::OFF_ZERO)
  // the Y axis fold leaves no residual
  `CHP_ASSERT_IMP(a_axis_fold, v[0] && d[0].x == '0, d[0].y == '0)
  // rotations never push X negative
  `CHP_ASSERT_IMP(a_x_nonneg, v[chp_pkg::N_CELLS], !d[chp_pkg::N_CELLS].x[chp_pkg::VW-1])
  `CHP_ASSERT_IMP(a_head_range, out_valid, heading_deg <= chp_pkg::HEAD_MAX)

endmodule

>>> rtl/core/chp_pre_cell.sv
// Entry cell: folds the sample into the right half-plane and scales it.
// Depends on chp_pkg.
module chp_pre_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  axis_x,
  input  logic signed [15:0]  axis_y,
  output logic                dn_valid,
  input  logic                dn_ready,
  output chp_pkg::vec_t       dn_data
);

  logic signed [17:0]          xs, ys, xr, yr;
  logic [chp_pkg::BW-1:0]      base;
  chp_pkg::vec_t               nxt;

  always_comb begin
    xs   = {{2{axis_x[15]}}, axis_x};
    ys   = {{2{axis_y[15]}}, axis_y};
    xr   = xs;
    yr   = ys;
    base = chp_pkg::OFF_ZERO;
    if (xs[17]) begin
      // turn by half a revolution
      base = ys[17] ? chp_pkg::OFF_NEG_HALF : chp_pkg::OFF_POS_HALF;
      xr   = -xs;
      yr   = -ys;
    end else if (xs == 18'sd0) begin
      // on the Y axis: turn by a quarter; both zero keeps 180
      if (ys == 18'sd0) begin
        base = chp_pkg::OFF_ZERO;
      end else if (!ys[17]) begin
        base = chp_pkg::OFF_UP;
        xr   = ys;
      end else begin
        base = chp_pkg::OFF_DOWN;
        xr   = -ys;
      end
      yr = '0;
    end
    nxt.x    = {{(chp_pkg::VW-18-chp_pkg::ANG_FRAC){xr[17]}}, xr, {chp_pkg::ANG_FRAC{1'b0}}};
    nxt.y    = {{(chp_pkg::VW-18-chp_pkg::ANG_FRAC){yr[17]}}, yr, {chp_pkg::ANG_FRAC{1'b0}}};
    nxt.z    = '0;
    nxt.base = base;
  end

  assign in_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (in_ready) begin
      dn_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dn_data <= nxt;
    end
  end

endmodule

>>> rtl/core/chp_cordic_cell.sv
// One vectoring rotation of the CORDIC chain, with its own register.
// Depends on chp_pkg.
module chp_cordic_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [chp_pkg::IDX_W-1:0]    stage,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  chp_pkg::vec_t                up_data,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output chp_pkg::vec_t                dn_data
);

  logic signed [chp_pkg::VW-1:0] xi, yi, dx, dy;
  logic signed [chp_pkg::ZW-1:0] zi, ang;
  chp_pkg::vec_t                 nxt;

  always_comb begin
    xi  = up_data.x;
    yi  = up_data.y;
    zi  = up_data.z;
    dx  = yi >>> stage;
    dy  = xi >>> stage;
    ang = chp_pkg::atan_deg(stage);
    nxt = up_data;
    // a zero residual passes straight through
    if (yi != '0) begin
      if (!yi[chp_pkg::VW-1]) begin
        nxt.x = xi + dx;
        nxt.y = yi - dy;
        nxt.z = zi + ang;
      end else begin
        nxt.x = xi - dx;
        nxt.y = yi + dy;
        nxt.z = zi - ang;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= nxt;
    end
  end

endmodule

>>> rtl/core/chp_out_cell.sv
// Exit cell: adds base and angle, floors to whole degrees, clamps to 0..360.
// Depends on chp_pkg.
module chp_out_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  chp_pkg::vec_t  up_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [8:0]     heading_deg
);

  logic signed [chp_pkg::HW-1:0]           hf;
  logic [chp_pkg::HW-chp_pkg::ANG_FRAC-1:0] hi;
  logic [8:0]                              head;

  always_comb begin
    hf = $signed({{(chp_pkg::HW-chp_pkg::BW-chp_pkg::ANG_FRAC){1'b0}}, up_data.base,
                  {chp_pkg::ANG_FRAC{1'b0}}})
       + $signed({{(chp_pkg::HW-chp_pkg::ZW){up_data.z[chp_pkg::ZW-1]}}, up_data.z});
    hi = hf[chp_pkg::HW-1:chp_pkg::ANG_FRAC];
    if (hf[chp_pkg::HW-1]) begin
      head = '0;
    end else if (hi > {{(chp_pkg::HW-chp_pkg::ANG_FRAC-9){1'b0}}, chp_pkg::HEAD_MAX}) begin
      head = chp_pkg::HEAD_MAX;
    end else begin
      head = hi[8:0];
    end
  end

  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      heading_deg <= head;
    end
  end

endmodule
